// ===== sv/swfrm_pkg.sv =====
// ============================================================================
// Frame-rate meter package
// Shared constants, command codes and controller states of the meter.
// ============================================================================
`default_nettype none

package swfrm_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int RESET_WINDOW   = 60;
    localparam int STAMP_W        = 32;
    localparam int CMD_W          = 2;
    localparam int CFG_W          = 8;
    localparam int RATE_W         = 26;
    localparam int SCALE_W        = 18;

    // 1000 ms per second times 256 for the Q8 fraction.
    localparam logic [SCALE_W-1:0] RATE_SCALE = 18'd256000;
    localparam logic [RATE_W-1:0]  RATE_MAX   = 26'h3FF_FFFF;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REPLACE,
        ST_EVAL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== sv/swfrm_div.sv =====
// ============================================================================
// Frame-rate meter divider
// Restoring divider that retires one quotient bit per clock cycle.
// ============================================================================
`default_nettype none

module swfrm_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [NUM_W-1:0] r_q;
    logic [NUM_W-1:0] n_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] n_rem;
    logic [DEN_W:0]   trial;
    logic             fits;

    // The numerator shifts out of the top of r_q while quotient bits enter at the bottom.
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign fits  = (trial >= {1'b0, i_den});

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
            n_q    = i_num;
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = {r_q[NUM_W-2:0], fits};
            n_rem = fits ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== sv/sliding_window_frame_rate_meter_top.sv =====
// ============================================================================
// Sliding-window frame-rate meter
// Averages recent frame intervals and reports frames per second in Q8.
// ============================================================================
// Every input word returns exactly one output word. Start, stop and illegal
// commands pass through the decode and finish states to the output register.
// A frame tick adds an eval state and, unless the sum is zero, the bit-serial
// divider, which produces one quotient bit per cycle for a quotient of
// NUM_W = 18 + clog2(MAX_WINDOW + 1) bits. The frame intervals live in a
// single-port-write, registered-read ring memory of MAX_WINDOW entries; a
// tick that retires the oldest interval adds a replace state that takes the
// interval read back out of the sum. The ring needs no clearing after reset
// since only written entries are ever read. Window register writes are taken
// at any time and reload the effective window at once.
`default_nettype none

module sliding_window_frame_rate_meter_top #(
    parameter int  MAX_WINDOW = swfrm_pkg::MAX_WINDOW_DEF,
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1),
    localparam int OUT_BITS   = swfrm_pkg::RATE_W + 3 + WIN_W + swfrm_pkg::STAMP_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // time_ms
    input  wire logic [swfrm_pkg::STAMP_W-1:0]  i_s_tdata,
    // command
    input  wire logic [swfrm_pkg::CMD_W-1:0]    i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // rate_q8, rate_updated, window_now, window_doubled, frames_seen, misuse
    output logic [OUT_W-1:0]                    o_m_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [swfrm_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W   = swfrm_pkg::STAMP_W + PTR_W;
    localparam int NUM_W   = swfrm_pkg::SCALE_W + WIN_W;
    localparam int RATE_W  = swfrm_pkg::RATE_W;
    localparam int STAMP_W = swfrm_pkg::STAMP_W;
    localparam int CMD_W   = swfrm_pkg::CMD_W;
    localparam int WIN_RST = (swfrm_pkg::RESET_WINDOW > MAX_WINDOW) ?
                             MAX_WINDOW : swfrm_pkg::RESET_WINDOW;

    swfrm_pkg::t_state   r_state;
    swfrm_pkg::t_state   n_state;

    logic [CMD_W-1:0]    r_cmd;
    logic [CMD_W-1:0]    n_cmd;
    logic [STAMP_W-1:0]  r_time;
    logic [STAMP_W-1:0]  n_time;
    logic [STAMP_W-1:0]  r_last;
    logic [STAMP_W-1:0]  n_last;
    logic [STAMP_W-1:0]  r_delta;
    logic [STAMP_W-1:0]  n_delta;
    logic [PTR_W-1:0]    r_oldest;
    logic [PTR_W-1:0]    n_oldest;
    logic [WIN_W-1:0]    r_fill;
    logic [WIN_W-1:0]    n_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic                r_running;
    logic                n_running;
    logic [WIN_W-1:0]    r_win;
    logic [WIN_W-1:0]    n_win;
    logic [RATE_W-1:0]   r_rate;
    logic [RATE_W-1:0]   n_rate;
    logic [STAMP_W-1:0]  r_ticks;
    logic [STAMP_W-1:0]  n_ticks;
    logic                r_upd;
    logic                n_upd;
    logic                r_dbl;
    logic                n_dbl;
    logic                r_mis;
    logic                n_mis;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    n_num;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic [OUT_W-1:0]    n_out_data;

    logic [STAMP_W-1:0]  ring_mem [MAX_WINDOW];
    logic [STAMP_W-1:0]  r_rd_data;
    logic                mem_we;
    logic [PTR_W-1:0]    mem_waddr;

    logic [STAMP_W-1:0]  delta_now;
    logic [WIN_W:0]      pos_sum;
    logic [PTR_W-1:0]    pos_wrap;
    logic [PTR_W-1:0]    oldest_inc;
    logic [WIN_W:0]      win_dbl;
    logic [WIN_W-1:0]    cfg_win;
    logic                out_load;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [RATE_W-1:0]   rate_sat;

    assign delta_now = r_time - r_last;

    // Slot after the newest entry; fill is below the window here, so one wrap suffices.
    assign pos_sum  = {1'b0, r_fill} + (WIN_W + 1)'(r_oldest);
    assign pos_wrap = (pos_sum >= (WIN_W + 1)'(MAX_WINDOW)) ?
                      PTR_W'(pos_sum - (WIN_W + 1)'(MAX_WINDOW)) : PTR_W'(pos_sum);
    assign oldest_inc = (r_oldest == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_oldest + PTR_W'(1);

    assign win_dbl = {r_win, 1'b0};

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_win = WIN_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            cfg_win = WIN_W'(MAX_WINDOW);
        end else begin
            cfg_win = WIN_W'(i_cfg_data);
        end
    end

    assign rate_sat = (32'(div_quot) > 32'(swfrm_pkg::RATE_MAX)) ?
                      swfrm_pkg::RATE_MAX : RATE_W'(div_quot);

    assign out_load = (r_state == swfrm_pkg::ST_FINISH) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_time    = r_time;
        n_last    = r_last;
        n_delta   = r_delta;
        n_oldest  = r_oldest;
        n_fill    = r_fill;
        n_sum     = r_sum;
        n_running = r_running;
        n_win     = r_win;
        n_rate    = r_rate;
        n_ticks   = r_ticks;
        n_upd     = r_upd;
        n_dbl     = r_dbl;
        n_mis     = r_mis;
        n_num     = r_num;
        mem_we    = 1'b0;
        mem_waddr = r_oldest;
        div_start = 1'b0;

        unique case (r_state)
            swfrm_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = i_s_tuser;
                    n_time  = i_s_tdata;
                    n_upd   = 1'b0;
                    n_dbl   = 1'b0;
                    n_mis   = 1'b0;
                    n_state = swfrm_pkg::ST_DECODE;
                end
            end
            swfrm_pkg::ST_DECODE: begin
                n_state = swfrm_pkg::ST_FINISH;
                case (r_cmd)
                    swfrm_pkg::CMD_START: begin
                        if (r_running) begin
                            n_mis = 1'b1;
                        end else begin
                            n_running = 1'b1;
                            n_last    = r_time;
                        end
                    end
                    swfrm_pkg::CMD_STOP: begin
                        if (r_running) begin
                            n_running = 1'b0;
                        end else begin
                            n_mis = 1'b1;
                        end
                    end
                    swfrm_pkg::CMD_TICK: begin
                        if (!r_running) begin
                            n_mis = 1'b1;
                        end else begin
                            n_delta = delta_now;
                            n_ticks = r_ticks + STAMP_W'(1);
                            n_last  = r_time;
                            // The new delta joins the sum either way; a replaced entry is
                            // taken out in the next state once its read data is back.
                            n_sum   = r_sum + SUM_W'(delta_now);
                            if (r_fill >= r_win) begin
                                n_state = swfrm_pkg::ST_REPLACE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_wrap;
                                n_fill    = r_fill + WIN_W'(1);
                                n_state   = swfrm_pkg::ST_EVAL;
                            end
                        end
                    end
                    default: begin
                        n_mis = 1'b1;
                    end
                endcase
            end
            swfrm_pkg::ST_REPLACE: begin
                n_sum     = r_sum - SUM_W'(r_rd_data);
                mem_we    = 1'b1;
                mem_waddr = r_oldest;
                n_oldest  = oldest_inc;
                n_state   = swfrm_pkg::ST_EVAL;
            end
            swfrm_pkg::ST_EVAL: begin
                if (r_sum != '0) begin
                    n_num   = NUM_W'(swfrm_pkg::RATE_SCALE) * NUM_W'(r_fill);
                    n_state = swfrm_pkg::ST_DIV_GO;
                end else begin
                    if (r_fill == r_win) begin
                        n_win = (win_dbl > (WIN_W + 1)'(MAX_WINDOW)) ?
                                WIN_W'(MAX_WINDOW) : WIN_W'(win_dbl);
                        n_dbl = 1'b1;
                    end
                    n_state = swfrm_pkg::ST_FINISH;
                end
            end
            swfrm_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = swfrm_pkg::ST_DIV_WAIT;
            end
            swfrm_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_rate  = rate_sat;
                    n_upd   = 1'b1;
                    n_state = swfrm_pkg::ST_FINISH;
                end
            end
            swfrm_pkg::ST_FINISH: begin
                if (out_load) begin
                    n_state = swfrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swfrm_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_win = cfg_win;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = OUT_W'({r_mis, r_ticks, r_dbl, r_win, r_upd, r_rate});
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swfrm_pkg::ST_IDLE;
            r_last      <= '0;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_running   <= 1'b0;
            r_win       <= WIN_W'(WIN_RST);
            r_rate      <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_running   <= n_running;
            r_win       <= n_win;
            r_rate      <= n_rate;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_time     <= n_time;
        r_delta    <= n_delta;
        r_upd      <= n_upd;
        r_dbl      <= n_dbl;
        r_mis      <= n_mis;
        r_num      <= n_num;
        r_out_data <= n_out_data;
    end

    // Ring memory: one write port and one registered read port at the oldest entry.
    // The new delta comes straight from the subtractor on a push and from r_delta
    // on a replacement.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= (r_state == swfrm_pkg::ST_REPLACE) ? r_delta : delta_now;
        end
        r_rd_data <= ring_mem[r_oldest];
    end

    swfrm_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_s_tready  = (r_state == swfrm_pkg::ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== sv/swfrm_checker.sv =====
// ============================================================================
// Frame-rate meter port checker
// Watches the meter's ports for inconsistent output words.
// ============================================================================
`default_nettype none

module swfrm_checker #(
    parameter int MAX_WINDOW = swfrm_pkg::MAX_WINDOW_DEF,
    parameter int OUT_W      = 72
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int UPD_B  = swfrm_pkg::RATE_W;
    localparam int WIN_LO = UPD_B + 1;
    localparam int DBL_B  = WIN_LO + WIN_W;
    localparam int MIS_B  = DBL_B + 1 + swfrm_pkg::STAMP_W;

    logic             upd;
    logic             dbl;
    logic             mis;
    logic [WIN_W-1:0] win;

    assign upd = o_m_tdata[UPD_B];
    assign dbl = o_m_tdata[DBL_B];
    assign mis = o_m_tdata[MIS_B];
    assign win = o_m_tdata[WIN_LO +: WIN_W];

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_misuse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && mis |-> !upd && !dbl)
        else $error("ignored command changed rate or window");

    a_upd_xor_dbl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(upd && dbl))
        else $error("rate update and window doubling in one word");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (win != '0) && (32'(win) <= 32'(MAX_WINDOW)))
        else $error("window out of range");

endmodule

bind sliding_window_frame_rate_meter_top swfrm_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .OUT_W      (OUT_W)
) u_swfrm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
